>>> sv/jsu_pkg.sv
// ============================================================================
// jsu_pkg: shared types and constants of the JSON string unescape block
// Decode phases, command and result item layouts, character codes, sizes.
// ============================================================================
package jsu_pkg;

    // output buffer limit and length counter width
    localparam int unsigned MaxOutputBytes = 1024;
    localparam int unsigned LenW           = 11;
    localparam logic [LenW-1:0] CapReset   = LenW'(64);

    // command queue between front and back
    localparam int unsigned QDepth = 4;
    localparam int unsigned PtrW   = $clog2(QDepth);

    // status codes
    localparam logic [1:0] ST_RUN = 2'd0;
    localparam logic [1:0] ST_OK  = 2'd1;
    localparam logic [1:0] ST_ERR = 2'd2;

    // character codes
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    // decoder phase
    typedef enum logic [2:0] {
        PH_NORMAL,
        PH_ESC,
        PH_HEX1,
        PH_WANT_BS,
        PH_WANT_U,
        PH_HEX2
    } t_phase;

    // outcome of one input byte
    typedef enum logic [2:0] {
        K_IDLE,
        K_EMIT,
        K_FAIL,
        K_DONE,
        K_HOLD
    } t_kind;

    // command: nbytes 0 means one result without data, carrying status
    typedef struct packed {
        logic [20:0] cp;
        logic [2:0]  nbytes;
        logic [1:0]  status;
    } t_cmd;

    // one result item
    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic [1:0] status;
        logic       last;
    } t_item;

endpackage

>>> sv/jsu_front.sv
// ============================================================================
// jsu_front: input side of the JSON string unescape block
// Accepts one body byte per cycle while the command queue has room, runs the escape
// decoder and issues one command per byte: emit a code point, or report idle, success or error.
// ============================================================================
module jsu_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [7:0]               i_in_byte,
    input  logic                     i_first,
    input  logic                     i_cfg_wr_en,
    input  logic [jsu_pkg::LenW-1:0] i_cfg_wr_data,
    output logic                     o_cmd_valid,
    output jsu_pkg::t_cmd            o_cmd,
    input  logic                     i_cmd_ready
);

    // hex digit value, msb flags a valid digit
    function automatic logic [4:0] hex_of(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    jsu_pkg::t_phase            r_phase, n_phase, e_phase;
    logic [15:0]                r_acc, n_acc, e_acc;
    logic [1:0]                 r_cnt, n_cnt, e_cnt;
    logic [9:0]                 r_hs, n_hs, e_hs;
    logic [jsu_pkg::LenW-1:0]   r_len, n_len, e_len;
    logic [1:0]                 r_end, n_end, e_end;
    logic [jsu_pkg::LenW-1:0]   r_cap;

    logic                       accept;
    logic [4:0]                 hex;
    logic [15:0]                acc_new;
    logic                       v_high, v_low;
    logic [20:0]                cp_join;
    logic [2:0]                 n_bmp;
    logic [jsu_pkg::LenW-1:0]   cap;
    logic [jsu_pkg::LenW:0]     len_sum;
    jsu_pkg::t_kind             kind, kind_pre;
    logic [20:0]                emit_cp;
    logic [2:0]                 emit_n;

    assign accept      = i_valid && i_cmd_ready;
    assign o_ready     = i_cmd_ready;
    assign o_cmd_valid = i_valid;

    // capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= jsu_pkg::CapReset;
        end else if (i_cfg_wr_en) begin
            r_cap <= i_cfg_wr_data;
        end
    end

    assign cap = (r_cap > jsu_pkg::LenW'(jsu_pkg::MaxOutputBytes))
               ? jsu_pkg::LenW'(jsu_pkg::MaxOutputBytes) : r_cap;

    // state seen by this byte, start flag clears it
    always_comb begin
        if (i_first) begin
            e_phase = jsu_pkg::PH_NORMAL;
            e_acc   = 16'd0;
            e_cnt   = 2'd0;
            e_hs    = 10'd0;
            e_len   = '0;
            e_end   = jsu_pkg::ST_RUN;
        end else begin
            e_phase = r_phase;
            e_acc   = r_acc;
            e_cnt   = r_cnt;
            e_hs    = r_hs;
            e_len   = r_len;
            e_end   = r_end;
        end
    end

    // hex accumulation and code point forms
    assign hex     = hex_of(i_in_byte);
    assign acc_new = {e_acc[11:0], hex[3:0]};
    assign v_high  = acc_new >= 16'hD800 && acc_new <= 16'hDBFF;
    assign v_low   = acc_new >= 16'hDC00 && acc_new <= 16'hDFFF;
    assign cp_join = 21'h10000 + {1'b0, e_hs, acc_new[9:0]};
    assign n_bmp   = (acc_new <= 16'h007F) ? 3'd1 : (acc_new <= 16'h07FF) ? 3'd2 : 3'd3;

    // classify the byte
    always_comb begin
        kind_pre = jsu_pkg::K_IDLE;
        emit_cp  = {13'd0, i_in_byte};
        emit_n   = 3'd1;
        if (e_end != jsu_pkg::ST_RUN) begin
            kind_pre = jsu_pkg::K_HOLD;
        end else begin
            case (e_phase)
                jsu_pkg::PH_ESC: begin
                    case (i_in_byte)
                        jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH: begin
                            kind_pre = jsu_pkg::K_EMIT;
                        end
                        jsu_pkg::CH_B: begin
                            kind_pre = jsu_pkg::K_EMIT;
                            emit_cp  = 21'h08;
                        end
                        jsu_pkg::CH_F: begin
                            kind_pre = jsu_pkg::K_EMIT;
                            emit_cp  = 21'h0C;
                        end
                        jsu_pkg::CH_N: begin
                            kind_pre = jsu_pkg::K_EMIT;
                            emit_cp  = 21'h0A;
                        end
                        jsu_pkg::CH_R: begin
                            kind_pre = jsu_pkg::K_EMIT;
                            emit_cp  = 21'h0D;
                        end
                        jsu_pkg::CH_T: begin
                            kind_pre = jsu_pkg::K_EMIT;
                            emit_cp  = 21'h09;
                        end
                        jsu_pkg::CH_U: begin
                            kind_pre = jsu_pkg::K_IDLE;
                        end
                        default: begin
                            kind_pre = jsu_pkg::K_FAIL;
                        end
                    endcase
                end
                jsu_pkg::PH_HEX1: begin
                    emit_cp = {5'd0, acc_new};
                    emit_n  = n_bmp;
                    if (!hex[4]) begin
                        kind_pre = jsu_pkg::K_FAIL;
                    end else if (e_cnt != 2'd3 || v_high) begin
                        kind_pre = jsu_pkg::K_IDLE;
                    end else if (v_low || acc_new == 16'd0) begin
                        kind_pre = jsu_pkg::K_FAIL;
                    end else begin
                        kind_pre = jsu_pkg::K_EMIT;
                    end
                end
                jsu_pkg::PH_HEX2: begin
                    emit_cp = cp_join;
                    emit_n  = 3'd4;
                    if (!hex[4]) begin
                        kind_pre = jsu_pkg::K_FAIL;
                    end else if (e_cnt != 2'd3) begin
                        kind_pre = jsu_pkg::K_IDLE;
                    end else if (!v_low) begin
                        kind_pre = jsu_pkg::K_FAIL;
                    end else begin
                        kind_pre = jsu_pkg::K_EMIT;
                    end
                end
                jsu_pkg::PH_WANT_BS: begin
                    kind_pre = (i_in_byte == jsu_pkg::CH_BSLASH)
                             ? jsu_pkg::K_IDLE : jsu_pkg::K_FAIL;
                end
                jsu_pkg::PH_WANT_U: begin
                    kind_pre = (i_in_byte == jsu_pkg::CH_U)
                             ? jsu_pkg::K_IDLE : jsu_pkg::K_FAIL;
                end
                default: begin
                    if (i_in_byte == jsu_pkg::CH_QUOTE) begin
                        kind_pre = (e_len == '0 || e_len >= cap)
                                 ? jsu_pkg::K_FAIL : jsu_pkg::K_DONE;
                    end else if (i_in_byte < jsu_pkg::CH_SPACE) begin
                        kind_pre = jsu_pkg::K_FAIL;
                    end else if (i_in_byte == jsu_pkg::CH_BSLASH) begin
                        kind_pre = jsu_pkg::K_IDLE;
                    end else begin
                        kind_pre = jsu_pkg::K_EMIT;
                    end
                end
            endcase
        end
    end

    // room check for emitted bytes, one byte kept for the terminator
    assign len_sum = {1'b0, e_len} + (jsu_pkg::LenW+1)'(emit_n);
    assign kind    = (kind_pre == jsu_pkg::K_EMIT && len_sum >= {1'b0, cap})
                   ? jsu_pkg::K_FAIL : kind_pre;

    // next state
    always_comb begin
        n_phase = e_phase;
        n_acc   = e_acc;
        n_cnt   = e_cnt;
        n_hs    = e_hs;
        n_len   = e_len;
        n_end   = e_end;
        case (kind)
            jsu_pkg::K_FAIL: begin
                n_end = jsu_pkg::ST_ERR;
            end
            jsu_pkg::K_DONE: begin
                n_end = jsu_pkg::ST_OK;
            end
            jsu_pkg::K_EMIT: begin
                n_len   = len_sum[jsu_pkg::LenW-1:0];
                n_phase = jsu_pkg::PH_NORMAL;
                n_cnt   = 2'd0;
            end
            jsu_pkg::K_IDLE: begin
                case (e_phase)
                    jsu_pkg::PH_ESC: begin
                        n_phase = jsu_pkg::PH_HEX1;
                        n_acc   = 16'd0;
                        n_cnt   = 2'd0;
                    end
                    jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2: begin
                        n_acc = acc_new;
                        if (e_cnt != 2'd3) begin
                            n_cnt = e_cnt + 2'd1;
                        end else begin
                            // high surrogate, wait for its partner
                            n_cnt   = 2'd0;
                            n_hs    = acc_new[9:0];
                            n_phase = jsu_pkg::PH_WANT_BS;
                        end
                    end
                    jsu_pkg::PH_WANT_BS: begin
                        n_phase = jsu_pkg::PH_WANT_U;
                    end
                    jsu_pkg::PH_WANT_U: begin
                        n_phase = jsu_pkg::PH_HEX2;
                        n_acc   = 16'd0;
                        n_cnt   = 2'd0;
                    end
                    default: begin
                        n_phase = jsu_pkg::PH_ESC;
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    // command for the back end
    always_comb begin
        o_cmd = '0;
        case (kind)
            jsu_pkg::K_EMIT: begin
                o_cmd.cp     = emit_cp;
                o_cmd.nbytes = emit_n;
                o_cmd.status = jsu_pkg::ST_RUN;
            end
            jsu_pkg::K_FAIL: begin
                o_cmd.status = jsu_pkg::ST_ERR;
            end
            jsu_pkg::K_DONE: begin
                o_cmd.status = jsu_pkg::ST_OK;
            end
            jsu_pkg::K_HOLD: begin
                o_cmd.status = e_end;
            end
            default: begin
                o_cmd.status = jsu_pkg::ST_RUN;
            end
        endcase
    end

    // decoder state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= jsu_pkg::PH_NORMAL;
            r_acc   <= 16'd0;
            r_cnt   <= 2'd0;
            r_hs    <= 10'd0;
            r_len   <= '0;
            r_end   <= jsu_pkg::ST_RUN;
        end else if (accept) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_cnt   <= n_cnt;
            r_hs    <= n_hs;
            r_len   <= n_len;
            r_end   <= n_end;
        end
    end

endmodule

>>> sv/jsu_queue.sv
// ============================================================================
// jsu_queue: command queue between decoder front and output back end
// Small circular buffer of commands; lets each side stall on its own.
// ============================================================================
module jsu_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  jsu_pkg::t_cmd i_data,
    output logic          o_not_full,
    input  logic          i_pop,
    output logic          o_not_empty,
    output jsu_pkg::t_cmd o_head
);

    jsu_pkg::t_cmd                r_mem [jsu_pkg::QDepth];
    logic [jsu_pkg::PtrW-1:0]     r_wr_ptr, r_rd_ptr;
    logic [jsu_pkg::PtrW:0]       r_count;
    logic                         do_push, do_pop;

    assign o_not_full  = r_count != (jsu_pkg::PtrW+1)'(jsu_pkg::QDepth);
    assign o_not_empty = r_count != '0;
    assign o_head      = r_mem[r_rd_ptr];
    assign do_push     = i_push && o_not_full;
    assign do_pop      = i_pop && o_not_empty;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> sv/jsu_back.sv
// ============================================================================
// jsu_back: output side of the JSON string unescape block
// Expands each command into one to four result items, UTF-8 encoding code
// points, and presents them through a registered output stage.
// ============================================================================
module jsu_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_avail,
    input  jsu_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output jsu_pkg::t_item o_item
);

    // result item k of a command
    function automatic jsu_pkg::t_item item_of(input jsu_pkg::t_cmd cmd, input logic [1:0] k);
        jsu_pkg::t_item it;
        logic [1:0]     top_k;
        it.data   = 8'h00;
        it.valid  = 1'b0;
        it.status = cmd.status;
        top_k     = (cmd.nbytes == 3'd0) ? 2'd0 : 2'(cmd.nbytes - 3'd1);
        it.last   = (k == top_k);
        if (cmd.nbytes != 3'd0) begin
            it.valid = 1'b1;
            case (cmd.nbytes)
                3'd1: begin
                    it.data = cmd.cp[7:0];
                end
                3'd2: begin
                    it.data = (k == 2'd0) ? {3'b110, cmd.cp[10:6]} : {2'b10, cmd.cp[5:0]};
                end
                3'd3: begin
                    case (k)
                        2'd0:    it.data = {4'b1110, cmd.cp[15:12]};
                        2'd1:    it.data = {2'b10, cmd.cp[11:6]};
                        default: it.data = {2'b10, cmd.cp[5:0]};
                    endcase
                end
                default: begin
                    case (k)
                        2'd0:    it.data = {5'b11110, cmd.cp[20:18]};
                        2'd1:    it.data = {2'b10, cmd.cp[17:12]};
                        2'd2:    it.data = {2'b10, cmd.cp[11:6]};
                        default: it.data = {2'b10, cmd.cp[5:0]};
                    endcase
                end
            endcase
        end
        return it;
    endfunction

    jsu_pkg::t_cmd  r_cur;
    logic           r_cur_valid;
    logic [1:0]     r_idx;
    jsu_pkg::t_item r_out;
    logic           r_out_valid;

    logic           load;
    jsu_pkg::t_item cur_item, head_item;

    assign load      = !r_out_valid || i_ready;
    assign cur_item  = item_of(r_cur, r_idx);
    assign head_item = item_of(i_cmd, 2'd0);
    assign o_cmd_pop = load && !r_cur_valid && i_cmd_avail;
    assign o_valid   = r_out_valid;
    assign o_item    = r_out;

    // output register, payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= r_cur_valid ? cur_item : head_item;
        end
        if (o_cmd_pop) begin
            r_cur <= i_cmd;
        end
    end

    // sequencing of multi-byte commands
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= r_cur_valid || i_cmd_avail;
            if (r_cur_valid) begin
                if (cur_item.last) begin
                    r_cur_valid <= 1'b0;
                end else begin
                    r_idx <= r_idx + 2'd1;
                end
            end else if (i_cmd_avail && !head_item.last) begin
                r_cur_valid <= 1'b1;
                r_idx       <= 2'd1;
            end
        end
    end

endmodule

>>> sv/json_string_unescape_utf8.sv
// ============================================================================
// json_string_unescape_utf8: JSON string body decoder to UTF-8
// Unescapes string body bytes, joins surrogate pairs and encodes UTF-8.
// ============================================================================
// Usage:
//   Input channel (i_valid/o_ready): one body byte per transfer, starting
//   after the opening quote; i_first marks the first byte of a new string
//   and clears the decoder state before that byte is decoded.
//   Output channel (o_valid/i_ready): one to four result transfers per
//   input byte; o_last marks the final one. o_out_valid flags a data byte,
//   o_status reports in progress, finished ok or error.
//   Config: i_cfg_wr_en writes the output capacity (reset value 64); the
//   user must write it only while the block is idle, which no logic checks.
//   Throughput: one input byte per cycle while the queue has room; output
//   runs at one result per cycle while i_ready is high. A \u escape gives
//   one result per byte plus up to three more (fifteen results for a
//   twelve-byte surrogate pair), so long runs of them throttle the input
//   through o_ready. Each byte is decoded in its transfer cycle into a
//   four-entry command queue; its first result then moves from the queue
//   into the output register. When the receiver stalls, the queue fills
//   and o_ready falls after four pending commands.
//   Reset: queue and output stage empty, decoder in normal text, capacity 64.
// ============================================================================
module json_string_unescape_utf8 (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [7:0]               i_in_byte,
    input  logic                     i_first,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [7:0]               o_out_byte,
    output logic                     o_out_valid,
    output logic [1:0]               o_status,
    output logic                     o_last,
    input  logic                     i_cfg_wr_en,
    input  logic [jsu_pkg::LenW-1:0] i_cfg_wr_data
);

    jsu_pkg::t_cmd  cmd, head;
    logic           cmd_valid, q_ready, q_avail, q_pop;
    jsu_pkg::t_item item;

    // decoder front
    jsu_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_in_byte     (i_in_byte),
        .i_first       (i_first),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_cmd_valid   (cmd_valid),
        .o_cmd         (cmd),
        .i_cmd_ready   (q_ready)
    );

    // command queue
    jsu_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (cmd_valid),
        .i_data      (cmd),
        .o_not_full  (q_ready),
        .i_pop       (q_pop),
        .o_not_empty (q_avail),
        .o_head      (head)
    );

    // output back end
    jsu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_avail (q_avail),
        .i_cmd       (head),
        .o_cmd_pop   (q_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_item      (item)
    );

    assign o_out_byte  = item.data;
    assign o_out_valid = item.valid;
    assign o_status    = item.status;
    assign o_last      = item.last;

    // data bytes are only reported while the string is in progress
    a_data_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_valid |-> o_status == jsu_pkg::ST_RUN)
        else $error("data byte with end status");

    // an end status is a single result without data
    a_end_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != jsu_pkg::ST_RUN |-> o_last && !o_out_valid)
        else $error("end status not a lone last result");

    // results without data carry a zero byte and are last
    a_nodata_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_out_valid |-> o_out_byte == 8'h00 && o_last)
        else $error("non-data result with byte or not last");

endmodule

>>> test/testbench.sv
// ============================================================================
// testbench: JSON string unescape to UTF-8 decoder
// Drives string body bytes over the input channel and checks every result
// transfer against an in-bench decoder model (escapes, \u escapes, surrogate
// pairs, UTF-8 encoding, capacity limit, error and end status). Covers
// directed strings, malformed input, capacity settings, a long output stall
// and random well-formed strings with injected faults.
// ============================================================================
module testbench;

    // run control
    localparam int unsigned IDLE_PCT      = 14;
    localparam int unsigned HOLD_CYCLES   = 60;
    localparam int unsigned DRAIN_LIMIT   = 4000;
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam int unsigned WATCHDOG_TIME = 4_000_000;
    localparam int unsigned RANDOM_ITEMS  = 130;
    localparam int unsigned REPORT_LIMIT  = 10;

    // code point ranges and UTF-8 framing
    localparam int CP_MAX     = 'h10FFFF;
    localparam int SUR_HI_LO  = 'hD800;
    localparam int SUR_HI_HI  = 'hDBFF;
    localparam int SUR_LO_LO  = 'hDC00;
    localparam int SUR_LO_HI  = 'hDFFF;
    localparam int SUPP_BASE  = 'h10000;
    localparam logic [7:0] LEAD2 = 8'hC0;
    localparam logic [7:0] LEAD3 = 8'hE0;
    localparam logic [7:0] LEAD4 = 8'hF0;
    localparam logic [7:0] CONT  = 8'h80;

    // hex digit characters
    localparam logic [7:0] CH_0  = 8'h30;
    localparam logic [7:0] CH_9  = 8'h39;
    localparam logic [7:0] CH_LA = 8'h61;
    localparam logic [7:0] CH_LF = 8'h66;
    localparam logic [7:0] CH_UA = 8'h41;
    localparam logic [7:0] CH_UF = 8'h46;

    // control codes produced by the short escapes
    localparam logic [7:0] CC_BACKSPACE = 8'h08;
    localparam logic [7:0] CC_TAB       = 8'h09;
    localparam logic [7:0] CC_NEWLINE   = 8'h0A;
    localparam logic [7:0] CC_FORMFEED  = 8'h0C;
    localparam logic [7:0] CC_RETURN    = 8'h0D;

    // block ports
    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic                     i_valid       = 1'b0;
    logic                     o_ready;
    logic [7:0]               i_in_byte     = '0;
    logic                     i_first       = 1'b0;
    logic                     o_valid;
    logic                     i_ready       = 1'b0;
    logic [7:0]               o_out_byte;
    logic                     o_out_valid;
    logic [1:0]               o_status;
    logic                     o_last;
    logic                     i_cfg_wr_en   = 1'b0;
    logic [jsu_pkg::LenW-1:0] i_cfg_wr_data = '0;

    // decoder model state
    jsu_pkg::t_phase          phase;
    logic [15:0]              hex_acc;
    logic [1:0]               hex_cnt;
    logic [9:0]               hi_sur;
    int                       out_len;
    logic [1:0]               end_st;
    logic [jsu_pkg::LenW-1:0] cap_reg;

    // results of one input byte, then the store of decoded results in flight
    jsu_pkg::t_item  step_res [4];
    int              step_n;
    jsu_pkg::t_item  decoded_q [$];

    // stimulus text and bookkeeping
    logic [7:0]      text_buf [$];
    int unsigned     items_sent = 0;
    int unsigned     fail_count = 0;
    logic            no_idle    = 1'b0;
    int unsigned     hold_req   = 0;
    int unsigned     hold_done  = 0;
    int unsigned     hold_left  = 0;

    json_string_unescape_utf8 i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_in_byte     (i_in_byte),
        .i_first       (i_first),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_byte    (o_out_byte),
        .o_out_valid   (o_out_valid),
        .o_status      (o_status),
        .o_last        (o_last),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    // clock
    always #10 i_clk = ~i_clk;

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) $display("ERROR: %s", msg);
    endfunction

    // ------------------------------------------------------------------------
    // decoder model
    // ------------------------------------------------------------------------
    function automatic void clear_decoder();
        phase   = jsu_pkg::PH_NORMAL;
        hex_acc = '0;
        hex_cnt = '0;
        hi_sur  = '0;
        out_len = 0;
        end_st  = jsu_pkg::ST_RUN;
    endfunction

    function automatic int eff_cap();
        return (cap_reg > jsu_pkg::MaxOutputBytes) ? int'(jsu_pkg::MaxOutputBytes)
                                                   : int'(cap_reg);
    endfunction

    function automatic void put_res(logic [7:0] d, logic v, logic [1:0] st);
        step_res[step_n] = '{data: d, valid: v, status: st, last: 1'b0};
        step_n++;
    endfunction

    function automatic void decode_fail();
        end_st = jsu_pkg::ST_ERR;
        put_res(8'h00, 1'b0, jsu_pkg::ST_ERR);
    endfunction

    function automatic int hex_nibble(logic [7:0] c);
        if (c >= CH_0 && c <= CH_9) return int'(c) - int'(CH_0);
        if (c >= CH_LA && c <= CH_LF) return int'(c) - int'(CH_LA) + 10;
        if (c >= CH_UA && c <= CH_UF) return int'(c) - int'(CH_UA) + 10;
        return -1;
    endfunction

    // one code point to one..four UTF-8 bytes
    function automatic void encode_cp(logic [20:0] cp);
        int n;
        if (cp == 0 || cp > CP_MAX || (cp >= SUR_HI_LO && cp <= SUR_LO_HI)) begin
            decode_fail();
            return;
        end
        n = (cp <= 'h7F) ? 1 : (cp <= 'h7FF) ? 2 : (cp <= 'hFFFF) ? 3 : 4;
        if (out_len + n >= eff_cap()) begin
            decode_fail();
            return;
        end
        case (n)
            1: begin
                put_res(cp[7:0], 1'b1, jsu_pkg::ST_RUN);
            end
            2: begin
                put_res(LEAD2 | 8'(cp[10:6]), 1'b1, jsu_pkg::ST_RUN);
                put_res(CONT | 8'(cp[5:0]), 1'b1, jsu_pkg::ST_RUN);
            end
            3: begin
                put_res(LEAD3 | 8'(cp[15:12]), 1'b1, jsu_pkg::ST_RUN);
                put_res(CONT | 8'(cp[11:6]), 1'b1, jsu_pkg::ST_RUN);
                put_res(CONT | 8'(cp[5:0]), 1'b1, jsu_pkg::ST_RUN);
            end
            default: begin
                put_res(LEAD4 | 8'(cp[20:18]), 1'b1, jsu_pkg::ST_RUN);
                put_res(CONT | 8'(cp[17:12]), 1'b1, jsu_pkg::ST_RUN);
                put_res(CONT | 8'(cp[11:6]), 1'b1, jsu_pkg::ST_RUN);
                put_res(CONT | 8'(cp[5:0]), 1'b1, jsu_pkg::ST_RUN);
            end
        endcase
        out_len += n;
    endfunction

    function automatic void decode_byte(logic [7:0] c);
        int          d;
        logic [15:0] v;
        logic [7:0]  lit;
        case (phase)
            // letter after a backslash
            jsu_pkg::PH_ESC: begin
                phase = jsu_pkg::PH_NORMAL;
                case (c)
                    jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH: lit = c;
                    jsu_pkg::CH_B: lit = CC_BACKSPACE;
                    jsu_pkg::CH_F: lit = CC_FORMFEED;
                    jsu_pkg::CH_N: lit = CC_NEWLINE;
                    jsu_pkg::CH_R: lit = CC_RETURN;
                    jsu_pkg::CH_T: lit = CC_TAB;
                    jsu_pkg::CH_U: begin
                        phase   = jsu_pkg::PH_HEX1;
                        hex_acc = '0;
                        hex_cnt = '0;
                        put_res(8'h00, 1'b0, jsu_pkg::ST_RUN);
                        return;
                    end
                    default: begin
                        decode_fail();
                        return;
                    end
                endcase
                if (out_len + 1 >= eff_cap()) begin
                    decode_fail();
                end else begin
                    out_len++;
                    put_res(lit, 1'b1, jsu_pkg::ST_RUN);
                end
            end
            // four hex digits, first or second half of a pair
            jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2: begin
                d = hex_nibble(c);
                if (d < 0) begin
                    decode_fail();
                    return;
                end
                hex_acc = {hex_acc[11:0], d[3:0]};
                if (hex_cnt < 3) begin
                    hex_cnt++;
                    put_res(8'h00, 1'b0, jsu_pkg::ST_RUN);
                    return;
                end
                hex_cnt = '0;
                v = hex_acc;
                if (phase == jsu_pkg::PH_HEX1) begin
                    if (v >= SUR_HI_LO && v <= SUR_HI_HI) begin
                        hi_sur = 10'(int'(v) - SUR_HI_LO);
                        phase  = jsu_pkg::PH_WANT_BS;
                        put_res(8'h00, 1'b0, jsu_pkg::ST_RUN);
                        return;
                    end
                    if (v >= SUR_LO_LO && v <= SUR_LO_HI) begin
                        decode_fail();
                        return;
                    end
                    phase = jsu_pkg::PH_NORMAL;
                    encode_cp(21'(v));
                    return;
                end
                if (v < SUR_LO_LO || v > SUR_LO_HI) begin
                    decode_fail();
                    return;
                end
                phase = jsu_pkg::PH_NORMAL;
                encode_cp(21'(SUPP_BASE + (int'(hi_sur) << 10) + (int'(v) - SUR_LO_LO)));
            end
            jsu_pkg::PH_WANT_BS: begin
                if (c != jsu_pkg::CH_BSLASH) begin
                    decode_fail();
                end else begin
                    phase = jsu_pkg::PH_WANT_U;
                    put_res(8'h00, 1'b0, jsu_pkg::ST_RUN);
                end
            end
            jsu_pkg::PH_WANT_U: begin
                if (c != jsu_pkg::CH_U) begin
                    decode_fail();
                end else begin
                    phase   = jsu_pkg::PH_HEX2;
                    hex_acc = '0;
                    hex_cnt = '0;
                    put_res(8'h00, 1'b0, jsu_pkg::ST_RUN);
                end
            end
            // plain text
            default: begin
                if (c == jsu_pkg::CH_QUOTE) begin
                    if (out_len == 0 || out_len >= eff_cap()) begin
                        decode_fail();
                    end else begin
                        end_st = jsu_pkg::ST_OK;
                        put_res(8'h00, 1'b0, jsu_pkg::ST_OK);
                    end
                end else if (c < jsu_pkg::CH_SPACE) begin
                    decode_fail();
                end else if (c == jsu_pkg::CH_BSLASH) begin
                    phase = jsu_pkg::PH_ESC;
                    put_res(8'h00, 1'b0, jsu_pkg::ST_RUN);
                end else if (out_len + 1 >= eff_cap()) begin
                    decode_fail();
                end else begin
                    out_len++;
                    put_res(c, 1'b1, jsu_pkg::ST_RUN);
                end
            end
        endcase
    endfunction

    // expected results of one accepted input byte
    function automatic void predict_decode(logic [7:0] c, logic f);
        step_n = 0;
        if (f) clear_decoder();
        if (end_st != jsu_pkg::ST_RUN) put_res(8'h00, 1'b0, end_st);
        else decode_byte(c);
        step_res[step_n-1].last = 1'b1;
        for (int k = 0; k < step_n; k++) decoded_q.push_back(step_res[k]);
    endfunction

    // ------------------------------------------------------------------------
    // output side: random ready, long hold on request, result check
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_done) begin
            hold_done <= hold_req;
            hold_left <= HOLD_CYCLES;
            i_ready   <= 1'b0;
        end else if (no_idle) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // a transfer happens at the next rising edge; outputs are stable here
    always @(negedge i_clk) begin
        jsu_pkg::t_item got;
        jsu_pkg::t_item want;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{data: o_out_byte, valid: o_out_valid, status: o_status, last: o_last};
            if (decoded_q.size() == 0) begin
                note_failure($sformatf("unexpected result: byte %02h valid %0b st %0d last %0b",
                    got.data, got.valid, got.status, got.last));
            end else begin
                want = decoded_q.pop_front();
                if (got.data !== want.data || got.valid !== want.valid ||
                    got.status !== want.status || got.last !== want.last) begin
                    note_failure($sformatf(
                        "exp byte %02h valid %0b st %0d last %0b, got %02h %0b %0d %0b",
                        want.data, want.valid, want.status, want.last,
                        got.data, got.valid, got.status, got.last));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic f);
        logic took;
        // random one-cycle gap before this transfer
        if (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_byte <= b;
        i_first   <= f;
        do begin
            @(negedge i_clk);
            took = o_ready;
            @(posedge i_clk);
        end while (!took);
        predict_decode(b, f);
        items_sent++;
    endtask

    task automatic send_text();
        for (int k = 0; k < text_buf.size(); k++) send_byte(text_buf[k], k == 0);
        text_buf.delete();
    endtask

    // drop valid, wait for every expected result, then let the pipe settle
    task automatic wait_idle();
        int unsigned spin;
        spin = 0;
        i_valid <= 1'b0;
        while (decoded_q.size() != 0 && spin < DRAIN_LIMIT) begin
            @(posedge i_clk);
            spin++;
        end
        if (decoded_q.size() != 0) begin
            note_failure($sformatf("%0d results never arrived", decoded_q.size()));
            decoded_q.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_capacity(input logic [jsu_pkg::LenW-1:0] v);
        wait_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cap_reg = v;
    endtask

    // ------------------------------------------------------------------------
    // text builders
    // ------------------------------------------------------------------------
    function automatic void add_str(string s);
        for (int k = 0; k < s.len(); k++) text_buf.push_back(s[k]);
    endfunction

    function automatic void add_hex4(logic [15:0] v);
        logic [3:0] nib;
        logic       upper;
        text_buf.push_back(jsu_pkg::CH_BSLASH);
        text_buf.push_back(jsu_pkg::CH_U);
        for (int k = 3; k >= 0; k--) begin
            nib   = v[k*4 +: 4];
            upper = $urandom_range(0, 1);
            if (nib < 10) text_buf.push_back(CH_0 + 8'(nib));
            else text_buf.push_back((upper ? CH_UA : CH_LA) + 8'(nib) - 8'd10);
        end
    endfunction

    function automatic void add_plain();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(jsu_pkg::CH_SPACE, 8'hFF));
        end while (c == jsu_pkg::CH_QUOTE || c == jsu_pkg::CH_BSLASH);
        text_buf.push_back(c);
    endfunction

    function automatic void add_short_escape();
        logic [7:0] letters [8];
        letters = '{jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH, jsu_pkg::CH_B,
                    jsu_pkg::CH_F, jsu_pkg::CH_N, jsu_pkg::CH_R, jsu_pkg::CH_T};
        text_buf.push_back(jsu_pkg::CH_BSLASH);
        text_buf.push_back(letters[$urandom_range(0, 7)]);
    endfunction

    // random code point of one to four UTF-8 bytes, never zero or a surrogate
    function automatic void add_codepoint();
        int unsigned cp;
        case ($urandom_range(0, 3))
            0: add_hex4(16'($urandom_range(1, 'h7F)));
            1: add_hex4(16'($urandom_range('h80, 'h7FF)));
            2: begin
                do begin
                    cp = $urandom_range('h800, 'hFFFF);
                end while (cp >= SUR_HI_LO && cp <= SUR_LO_HI);
                add_hex4(16'(cp));
            end
            default: begin
                cp = $urandom_range(SUPP_BASE, CP_MAX) - SUPP_BASE;
                add_hex4(16'(SUR_HI_LO + (cp >> 10)));
                add_hex4(16'(SUR_LO_LO + (cp & 'h3FF)));
            end
        endcase
    endfunction

    // well-formed string with random content, sometimes broken
    function automatic void build_random_string(int min_tok, int max_tok, bit with_faults);
        int unsigned ntok;
        int unsigned fault;
        int unsigned kind;
        ntok = $urandom_range(min_tok, max_tok);
        for (int k = 0; k < ntok; k++) begin
            kind = $urandom_range(0, 9);
            if (kind < 5) add_plain();
            else if (kind < 7) add_short_escape();
            else add_codepoint();
        end
        fault = with_faults ? $urandom_range(0, 99) : 100;
        if (fault < 8 && text_buf.size() > 0) begin
            // noise byte somewhere in the body
            text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(0, 255));
            text_buf.push_back(jsu_pkg::CH_QUOTE);
        end else if (fault < 14 && text_buf.size() > 0) begin
            // cut short, next string restarts the decoder mid-escape or mid-text
            repeat ($urandom_range(0, text_buf.size() - 1)) void'(text_buf.pop_back());
        end else begin
            text_buf.push_back(jsu_pkg::CH_QUOTE);
        end
        // bytes after the end
        if (with_faults && $urandom_range(0, 99) < 10)
            repeat ($urandom_range(1, 2)) text_buf.push_back(8'($urandom_range(0, 255)));
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_simple_escapes();
        // plain bytes including the top of the range, every short escape, bytes after end
        add_str("A");
        text_buf.push_back(8'hFF);
        add_str("\\\"\\\\\\/\\b\\f\\n\\r\\t\"x");
        send_text();
    endtask

    task automatic test_unicode_escapes();
        // two-byte code point, then a surrogate pair giving four bytes
        add_str("\\u00E9\\uD83D\\ude00\"");
        send_text();
        // three-byte code point
        add_str("\\u20ac\"");
        send_text();
    endtask

    task automatic test_malformed_input();
        // empty string
        add_str("\"");
        send_text();
        // zero byte ends the text, later byte sees the held error
        text_buf.push_back(8'h00);
        add_str("x");
        send_text();
        // zero byte inside an escape
        add_str("a\\");
        text_buf.push_back(8'h00);
        send_text();
        // unknown escape letter
        add_str("\\q");
        send_text();
        // bad hex digit
        add_str("\\uG");
        send_text();
        // code point zero
        add_str("\\u0000");
        send_text();
        // lone low surrogate
        add_str("\\uDC00");
        send_text();
        // high surrogate followed by plain text
        add_str("\\uD800a");
        send_text();
        // high surrogate followed by a backslash and a wrong letter
        add_str("\\uDBFF\\x");
        send_text();
        // high surrogate followed by a code point that is no low surrogate
        add_str("\\uD800\\u0041");
        send_text();
    endtask

    task automatic test_capacity_limits();
        // zero capacity: every data byte and every closing quote fails
        set_capacity(11'd0);
        add_str("a");
        send_text();
        add_str("\"");
        send_text();
        // capacity one leaves no room for any byte
        set_capacity(11'd1);
        add_str("a");
        send_text();
        // capacity two takes one byte
        set_capacity(11'd2);
        add_str("ab");
        send_text();
        // multi-byte code point overflowing the buffer
        set_capacity(11'd3);
        add_str("a\\u20AC\"");
        send_text();
        // value above the buffer limit
        set_capacity(11'h7FF);
        add_str("ab\"");
        send_text();
    endtask

    task automatic test_output_stall();
        set_capacity(11'd1024);
        hold_req <= hold_req + 1;
        build_random_string(10, 14, 1'b0);
        send_text();
    endtask

    task automatic test_random_strings();
        logic [jsu_pkg::LenW-1:0] caps [8];
        int unsigned              phase_end;
        caps = '{11'd64, 11'd5, 11'd12, 11'd1024, 11'd2, 11'd300, 11'h7FF, 11'd1};
        for (int p = 0; p < 10; p++) begin
            set_capacity(p < 8 ? caps[p] : jsu_pkg::LenW'($urandom_range(0, 2047)));
            // a stretch without any idle cycles on either side
            no_idle   <= (p == 3 || p == 4);
            phase_end = items_sent + RANDOM_ITEMS / 10;
            while (items_sent < phase_end) begin
                build_random_string(0, 16, 1'b1);
                send_text();
            end
        end
        no_idle <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        clear_decoder();
        cap_reg = jsu_pkg::CapReset;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_simple_escapes();
        test_unicode_escapes();
        test_malformed_input();
        test_capacity_limits();
        test_output_stall();
        test_random_strings();
        wait_idle();

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // run limit
    initial begin
        #(WATCHDOG_TIME);
        $display("Test completed with failures");
        $finish;
    end

endmodule
